### rtl/setq_pkg.sv
`default_nettype none

package setq_pkg;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_ADJUST = 2'd1,
    OP_DELETE = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_PRESENT = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DECIDE,
    S_MV_RD,
    S_MV_WR,
    S_INS_WR,
    S_REPLY,
    S_TICK_RD,
    S_TICK_CHK,
    S_TICK_END
  } state_t;

  // Flags from the shared compare unit.
  typedef struct packed {
    logic le;
    logic hit;
  } cmp_res_t;

endpackage

`default_nettype wire

### rtl/setq_ram.sv
`default_nettype none

module setq_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; read data holds when idle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/setq_cmp.sv
`default_nettype none

module setq_cmp
  import setq_pkg::*;
#(
  parameter int TIME_BITS   = 32,
  parameter int HANDLE_BITS = 6
) (
  input  wire logic [TIME_BITS-1:0]   entry_time,
  input  wire logic [HANDLE_BITS-1:0] entry_handle,
  input  wire logic [TIME_BITS-1:0]   key_time,
  input  wire logic [HANDLE_BITS-1:0] key_handle,
  output cmp_res_t                    res
);

  // The one time comparator and handle matcher shared by every pass.
  always_comb begin
    res.le  = (entry_time <= key_time);
    res.hit = (entry_handle == key_handle);
  end

endmodule

`default_nettype wire

### rtl/sorted_expiry_timer_queue_core.sv
// Channel   Handshake              Payload
// request   in_valid / in_stall    op, handle, expiry, now_time
// result    out_valid / out_stall  status, expired_valid, expired_handle, last, occupancy
//
// Entries live in one RAM in ascending expiry order; a single comparator walks it.
// Add, adjust and delete scan every entry, then move a block of entries; add and adjust then
// write the key entry. A tick checks the head entries in order, then moves the rest down.
// The RAM has one read and one write port, and every pass shares the one comparator.
// rst is synchronous and empties the queue; the RAM contents need no clearing.
// The result register lets a new request in while a result waits; out_stall holds it.
`default_nettype none

module sorted_expiry_timer_queue_core
  import setq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 16,
  parameter int HANDLE_COUNT = 64,
  parameter int TIME_BITS    = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        op,
  input  wire logic [$clog2(HANDLE_COUNT)-1:0]   handle,
  input  wire logic [TIME_BITS-1:0]              expiry,
  input  wire logic [TIME_BITS-1:0]              now_time,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [1:0]                             status,
  output logic                                   expired_valid,
  output logic [$clog2(HANDLE_COUNT)-1:0]        expired_handle,
  output logic                                   last,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]       occupancy
);

  localparam int HANDLE_BITS = $clog2(HANDLE_COUNT);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
  localparam int WORD_BITS   = TIME_BITS + HANDLE_BITS;

  localparam logic [CNT_BITS-1:0]    ONE      = CNT_BITS'(1);
  localparam logic [CNT_BITS-1:0]    DEPTH_C  = CNT_BITS'(QUEUE_DEPTH);
  localparam logic [HANDLE_BITS:0]   HCOUNT_C = (HANDLE_BITS + 1)'(HANDLE_COUNT);

  // Sequencer and queue registers.
  state_t                  state, state_next;
  op_t                     op_q, op_q_next;
  logic [TIME_BITS-1:0]    key_time, key_time_next;
  logic [HANDLE_BITS-1:0]  key_handle, key_handle_next;
  logic                    in_range, in_range_next;
  logic [CNT_BITS-1:0]     count, count_next;
  logic [CNT_BITS-1:0]     idx, idx_next;
  logic [CNT_BITS-1:0]     le_cnt, le_cnt_next;
  logic                    found, found_next;
  logic [CNT_BITS-1:0]     fidx, fidx_next;
  status_t                 st_q, st_q_next;
  logic                    mv_up, mv_up_next;
  logic [CNT_BITS-1:0]     mv_ptr, mv_ptr_next;
  logic [CNT_BITS-1:0]     mv_len, mv_len_next;
  logic [CNT_BITS-1:0]     mv_gap, mv_gap_next;
  logic                    ins_do, ins_do_next;
  logic [CNT_BITS-1:0]     ins_pos, ins_pos_next;
  logic                    pend_valid, pend_valid_next;
  logic [HANDLE_BITS-1:0]  pend_handle, pend_handle_next;

  // RAM port signals.
  logic                    ram_wr_en;
  logic [CNT_BITS-1:0]     ram_wr_idx;
  logic [WORD_BITS-1:0]    ram_wr_data;
  logic                    ram_rd_en;
  logic [CNT_BITS-1:0]     ram_rd_idx;
  logic [WORD_BITS-1:0]    ram_rd_data;
  logic [TIME_BITS-1:0]    entry_time;
  logic [HANDLE_BITS-1:0]  entry_handle;
  cmp_res_t                cmp_res;

  // Result load signals.
  logic                    out_free;
  logic                    emit;
  status_t                 emit_status;
  logic                    emit_xv;
  logic [HANDLE_BITS-1:0]  emit_handle;
  logic                    emit_last;
  logic [CNT_BITS-1:0]     emit_occ;

  assign entry_time   = ram_rd_data[WORD_BITS-1:HANDLE_BITS];
  assign entry_handle = ram_rd_data[HANDLE_BITS-1:0];
  assign out_free     = !out_valid || !out_stall;
  assign in_stall     = (state != S_IDLE);

  setq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_idx[IDX_BITS-1:0]),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_idx[IDX_BITS-1:0]),
    .rd_data (ram_rd_data)
  );

  setq_cmp #(
    .TIME_BITS   (TIME_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_cmp (
    .entry_time   (entry_time),
    .entry_handle (entry_handle),
    .key_time     (key_time),
    .key_handle   (key_handle),
    .res          (cmp_res)
  );

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      pend_valid <= pend_valid_next;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    op_q        <= op_q_next;
    key_time    <= key_time_next;
    key_handle  <= key_handle_next;
    in_range    <= in_range_next;
    idx         <= idx_next;
    le_cnt      <= le_cnt_next;
    found       <= found_next;
    fidx        <= fidx_next;
    st_q        <= st_q_next;
    mv_up       <= mv_up_next;
    mv_ptr      <= mv_ptr_next;
    mv_len      <= mv_len_next;
    mv_gap      <= mv_gap_next;
    ins_do      <= ins_do_next;
    ins_pos     <= ins_pos_next;
    pend_handle <= pend_handle_next;
  end

  // Result register: loads on emit, empties when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status         <= emit_status;
      expired_valid  <= emit_xv;
      expired_handle <= emit_handle;
      last           <= emit_last;
      occupancy      <= emit_occ;
    end
  end

  // Sequencer: scan, decide, move entries, insert, reply; tick walks the head.
  always_comb begin
    state_next       = state;
    op_q_next        = op_q;
    key_time_next    = key_time;
    key_handle_next  = key_handle;
    in_range_next    = in_range;
    count_next       = count;
    idx_next         = idx;
    le_cnt_next      = le_cnt;
    found_next       = found;
    fidx_next        = fidx;
    st_q_next        = st_q;
    mv_up_next       = mv_up;
    mv_ptr_next      = mv_ptr;
    mv_len_next      = mv_len;
    mv_gap_next      = mv_gap;
    ins_do_next      = ins_do;
    ins_pos_next     = ins_pos;
    pend_valid_next  = pend_valid;
    pend_handle_next = pend_handle;

    ram_wr_en   = 1'b0;
    ram_wr_idx  = '0;
    ram_wr_data = ram_rd_data;
    ram_rd_en   = 1'b0;
    ram_rd_idx  = '0;

    emit        = 1'b0;
    emit_status = ST_OK;
    emit_xv     = 1'b0;
    emit_handle = '0;
    emit_last   = 1'b1;
    emit_occ    = count;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_q_next       = op_t'(op);
          key_handle_next = handle;
          key_time_next   = (op_t'(op) == OP_TICK) ? now_time : expiry;
          in_range_next   = ({1'b0, handle} < HCOUNT_C);
          idx_next        = '0;
          le_cnt_next     = '0;
          found_next      = 1'b0;
          fidx_next       = '0;
          pend_valid_next = 1'b0;
          state_next      = (op_t'(op) == OP_TICK) ? S_TICK_RD : S_SCAN_RD;
        end
      end

      // Walk every queued entry: find the handle, count other entries at or before the key.
      S_SCAN_RD: begin
        if (idx < count) begin
          ram_rd_en  = 1'b1;
          ram_rd_idx = idx;
          state_next = S_SCAN_CHK;
        end else begin
          state_next = S_DECIDE;
        end
      end

      S_SCAN_CHK: begin
        if (cmp_res.hit) begin
          found_next = 1'b1;
          fidx_next  = idx;
        end else if (cmp_res.le) begin
          le_cnt_next = le_cnt + ONE;
        end
        idx_next   = idx + ONE;
        state_next = S_SCAN_RD;
      end

      // Pick the status and set up the block move and the insert.
      S_DECIDE: begin
        mv_len_next = '0;
        mv_gap_next = ONE;
        ins_do_next = 1'b0;
        st_q_next   = ST_OK;
        unique case (op_q)
          OP_ADD: begin
            if (!in_range) begin
              st_q_next = ST_ABSENT;
            end else if (found) begin
              st_q_next = ST_PRESENT;
            end else if (count >= DEPTH_C) begin
              st_q_next = ST_FULL;
            end else begin
              mv_up_next   = 1'b1;
              mv_ptr_next  = count - ONE;
              mv_len_next  = count - le_cnt;
              ins_do_next  = 1'b1;
              ins_pos_next = le_cnt;
              count_next   = count + ONE;
            end
          end
          OP_ADJUST: begin
            if (!found) begin
              st_q_next = ST_ABSENT;
            end else begin
              ins_do_next  = 1'b1;
              ins_pos_next = le_cnt;
              if (le_cnt > fidx) begin
                mv_up_next  = 1'b0;
                mv_ptr_next = fidx + ONE;
                mv_len_next = le_cnt - fidx;
              end else if (le_cnt < fidx) begin
                mv_up_next  = 1'b1;
                mv_ptr_next = fidx - ONE;
                mv_len_next = fidx - le_cnt;
              end
            end
          end
          OP_DELETE: begin
            if (!found) begin
              st_q_next = ST_ABSENT;
            end else begin
              mv_up_next  = 1'b0;
              mv_ptr_next = fidx + ONE;
              mv_len_next = count - fidx - ONE;
              count_next  = count - ONE;
            end
          end
          OP_TICK: begin
            st_q_next = ST_OK;
          end
        endcase
        state_next = S_MV_RD;
      end

      // Block move, one entry per read and write pair.
      S_MV_RD: begin
        if (mv_len == '0) begin
          if (op_q == OP_TICK) begin
            state_next = S_IDLE;
          end else if (ins_do) begin
            state_next = S_INS_WR;
          end else begin
            state_next = S_REPLY;
          end
        end else begin
          ram_rd_en  = 1'b1;
          ram_rd_idx = mv_ptr;
          state_next = S_MV_WR;
        end
      end

      S_MV_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = ram_rd_data;
        if (mv_up) begin
          ram_wr_idx  = mv_ptr + ONE;
          mv_ptr_next = mv_ptr - ONE;
        end else begin
          ram_wr_idx  = mv_ptr - mv_gap;
          mv_ptr_next = mv_ptr + ONE;
        end
        mv_len_next = mv_len - ONE;
        state_next  = S_MV_RD;
      end

      S_INS_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_idx  = ins_pos;
        ram_wr_data = {key_time, key_handle};
        state_next  = S_REPLY;
      end

      S_REPLY: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = st_q;
          state_next  = S_IDLE;
        end
      end

      // Tick: read the head entries in order while they have expired.
      S_TICK_RD: begin
        if (idx < count) begin
          ram_rd_en  = 1'b1;
          ram_rd_idx = idx;
          state_next = S_TICK_CHK;
        end else begin
          state_next = S_TICK_END;
        end
      end

      // An expired entry is held back until the next one is checked so the final one can carry last.
      S_TICK_CHK: begin
        if (cmp_res.le) begin
          if (pend_valid) begin
            if (out_free) begin
              emit             = 1'b1;
              emit_xv          = 1'b1;
              emit_handle      = pend_handle;
              emit_last        = 1'b0;
              emit_occ         = count - idx;
              pend_handle_next = entry_handle;
              idx_next         = idx + ONE;
              state_next       = S_TICK_RD;
            end
          end else begin
            pend_valid_next  = 1'b1;
            pend_handle_next = entry_handle;
            idx_next         = idx + ONE;
            state_next       = S_TICK_RD;
          end
        end else begin
          state_next = S_TICK_END;
        end
      end

      // Send the final result, then close the gap left by the expired entries.
      S_TICK_END: begin
        if (out_free) begin
          emit = 1'b1;
          if (pend_valid) begin
            emit_xv     = 1'b1;
            emit_handle = pend_handle;
            emit_occ    = count - idx;
          end
          pend_valid_next = 1'b0;
          count_next      = count - idx;
          mv_up_next      = 1'b0;
          mv_ptr_next     = idx;
          mv_gap_next     = idx;
          mv_len_next     = (idx == '0) ? '0 : (count - idx);
          state_next      = S_MV_RD;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
